// ===== hdl/fltw_pkg.sv =====
// fltw_pkg: shared types, constants and codes for the page table walker
// no dependencies
`timescale 1ns / 1ps
package fltw_pkg;
  localparam int TableFramesDefault = 64;
  localparam int Entries = 512;
  localparam int IdxW = 9;
  localparam int PaW = 52;
  localparam int VaW = 48;

  localparam logic [1:0] CmdMap = 2'd0;
  localparam logic [1:0] CmdUnmap = 2'd1;
  localparam logic [1:0] CmdXlate = 2'd2;
  localparam logic [1:0] CmdNone = 2'd3;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StUnmapped = 2'd1;
  localparam logic [1:0] StNoFrame = 2'd2;
  localparam logic [1:0] StOutside = 2'd3;

  localparam logic [0:0] CfgTableBase = 1'b0;
  localparam logic [0:0] CfgRootFrame = 1'b1;

  typedef struct packed {
    logic [1:0] status;
    logic [PaW-1:0] phys_result;
  } result_t;
endpackage

// ===== hdl/fltw_store.sv =====
// fltw_store: table frame store, one write port and one registered read port
// depends on fltw_pkg
`timescale 1ns / 1ps
module fltw_store #(
  parameter int AddrW = 15
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [63:0]      wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [63:0]      rdata
);
  import fltw_pkg::*;
  logic [63:0] mem [2**AddrW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/four_level_page_table_walker.sv =====
// four_level_page_table_walker: four-level page table kept in an on-chip store
// uses fltw_pkg and fltw_store
//
// s_axis carries one command per transaction: tdata = command, virt_addr,
// phys_addr, flags_low, flags_high. m_axis returns one result per command:
// tdata = status, phys_result. cfg_we/cfg_index/cfg_data write table_base
// (index 0) and root_frame (index 1).
// A walk reads one entry per level, each read going through S_RD (address)
// and S_CHK (registered data, check). A missing level ends a translate or
// unmap earlier.
// Each newly allocated level first has all 512 entries of its frame cleared
// through the single write port.
// s_axis_tready is high only while idle, so a new command is taken at the
// earliest in the cycle after the previous result is loaded; no new command
// is taken before the walk of the last one is through.
// After reset the store is swept to zero, one entry per cycle, over all
// TABLE_FRAMES*512 entries (32768 by default); s_axis_tready stays low then.
// The result sits in an output register; a stalled receiver holds it and
// the next command is taken while it waits, but its walk result is only
// loaded into the output register after the previous one has left.
`timescale 1ns / 1ps
module four_level_page_table_walker #(
  parameter int TABLE_FRAMES = fltw_pkg::TableFramesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], virt_addr[49:2], phys_addr[101:50], flags_low[113:102],
  // flags_high[125:114], zero fill
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], phys_result[53:2], zero fill
  output logic [55:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [51:0]  cfg_data
);
  import fltw_pkg::*;
  localparam int FrW = $clog2(TABLE_FRAMES);
  localparam int AW = FrW + IdxW;
  localparam int CntW = FrW + 1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_ZERO = 7'b0010000,
    S_LEAF = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  logic [51:0] table_base;
  logic [5:0] root_frame;
  logic [CntW-1:0] next_free;
  logic [AW:0] clr_cnt;
  logic [1:0] cmd;
  logic [VaW-1:0] va;
  logic [PaW-1:0] pa;
  logic [11:0] fl, fh;
  logic [1:0] lvl;
  logic [FrW-1:0] frame, new_frame;
  logic [IdxW-1:0] zcnt;
  logic [AW-1:0] slot_q;
  result_t res;
  result_t out_q;
  logic out_valid;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata, rdata;

  fltw_store #(.AddrW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [IdxW-1:0] idx;
  logic [AW-1:0] slot;
  logic [PaW-13:0] off;
  logic ptr_ok;
  logic [CntW-1:0] alloc_c;
  logic alloc_ok;
  logic [PaW-13:0] nf_addr;

  always_comb begin
    unique case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    slot = {frame, idx};
    off = rdata[51:12] - table_base[51:12];
    ptr_ok = (off < (PaW-12)'(TABLE_FRAMES));
    alloc_c = (next_free == CntW'(root_frame)) ? next_free + 1'b1 : next_free;
    alloc_ok = (alloc_c < CntW'(TABLE_FRAMES));
    nf_addr = table_base[51:12] + (PaW-12)'(alloc_c);
  end

  assign raddr = slot;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {2'b00, out_q.phys_result, out_q.status};

  always_comb begin
    we = 1'b0;
    waddr = slot_q;
    wdata = '0;
    unique case (state)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_cnt[AW-1:0];
      end
      S_CHK: begin
        if (!rdata[0] && cmd == CmdMap && alloc_ok) begin
          we = 1'b1;
          wdata = {12'd0, nf_addr, 12'h007};
        end else if (lvl == 2'd3 && rdata[0] && cmd == CmdUnmap) begin
          we = 1'b1;
        end
      end
      S_ZERO: begin
        we = 1'b1;
        waddr = {new_frame, zcnt};
      end
      S_LEAF: begin
        we = 1'b1;
        wdata = {fh, pa[51:12], fl} | 64'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      next_free <= CntW'(1);
      table_base <= '0;
      root_frame <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgTableBase) table_base <= cfg_data;
        else root_frame <= cfg_data[5:0];
      end
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(TABLE_FRAMES * Entries - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cmd <= s_axis_tdata[1:0];
          va <= s_axis_tdata[49:2];
          pa <= s_axis_tdata[101:50];
          fl <= s_axis_tdata[113:102];
          fh <= s_axis_tdata[125:114];
          lvl <= 2'd0;
          frame <= FrW'(root_frame);
          res.phys_result <= '0;
          if (s_axis_tdata[1:0] == CmdNone) begin
            res.status <= StDone;
            state <= S_OUT;
          end else if (32'(root_frame) >= TABLE_FRAMES) begin
            res.status <= StOutside;
            state <= S_OUT;
          end else begin
            res.status <= StDone;
            state <= S_RD;
          end
        end
        S_RD: begin
          slot_q <= slot;
          state <= S_CHK;
        end
        S_CHK: begin
          if (lvl != 2'd3) begin
            if (!rdata[0]) begin
              if (cmd != CmdMap) begin
                res.status <= StUnmapped;
                state <= S_OUT;
              end else if (!alloc_ok) begin
                next_free <= CntW'(TABLE_FRAMES);
                res.status <= StNoFrame;
                state <= S_OUT;
              end else begin
                next_free <= alloc_c + 1'b1;
                new_frame <= alloc_c[FrW-1:0];
                frame <= alloc_c[FrW-1:0];
                zcnt <= '0;
                state <= S_ZERO;
              end
            end else if (!ptr_ok) begin
              res.status <= StOutside;
              state <= S_OUT;
            end else begin
              frame <= off[FrW-1:0];
              lvl <= lvl + 1'b1;
              state <= S_RD;
            end
          end else begin
            if (cmd == CmdMap) state <= S_LEAF;
            else begin
              if (!rdata[0]) res.status <= StUnmapped;
              else if (cmd == CmdXlate)
                res.phys_result <= {rdata[51:12], va[11:0]};
              state <= S_OUT;
            end
          end
        end
        S_ZERO: begin
          zcnt <= zcnt + 1'b1;
          if (zcnt == IdxW'(Entries - 1)) begin
            lvl <= lvl + 1'b1;
            state <= S_RD;
          end
        end
        S_LEAF: state <= S_OUT;
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          out_q <= res;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/fltw_checker.sv =====
// fltw_checker: port-level checks for the page table walker, bound to the top
// depends on four_level_page_table_walker ports
`timescale 1ns / 1ps
module fltw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after a transaction");
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("active after reset");
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[53:2] == '0)
    else $error("nonzero address on failure");
endmodule

bind four_level_page_table_walker fltw_checker u_fltw_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
